/* sv/wra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed running average: shared package
// Payload types, register indexes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wra_pkg;

    // Field widths fixed by the item format.
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 9;

    // Defaults handed to the top-level parameters.
    localparam int WINDOW_MAX_DEF = 256;
    localparam int SUM_W_DEF      = 40;

    // Window size after reset.
    localparam logic [CNT_W-1:0] WINDOW_SIZE_RST = 9'd16;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_TIME_MODE   = 1'b1
    } t_cfg_index;

    // One input beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STAMP_W-1:0]       timestamp;
        logic                     clear;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] delta;
        logic signed [DATA_W-1:0] average;
        logic signed [DATA_W-1:0] last_value;
        logic [CNT_W-1:0]         fill_count;
    } t_out_item;

    // One configuration write beat.
    typedef struct packed {
        t_cfg_index       index;
        logic [CNT_W-1:0] data;
    } t_cfg_beat;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic update;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Effective window: zero means one sample, and it saturates at wmax.
    function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] ws,
                                                    input int wmax);
        logic [CNT_W-1:0] n;
        n = ws;
        if (ws == '0) begin
            n = CNT_W'(1);
        end else if (int'(ws) > wmax) begin
            n = CNT_W'(wmax);
        end
        return n;
    endfunction

endpackage

/* sv/wra_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed running average: valid/ready channel
// Carries one payload beat from a source to a sink under a valid/ready
// handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface wra_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/wra_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed running average: controller
// Sequences a sample through ring update, divider load, the bit-serial
// division and hand-over to the output register; a clear just hands over.
// ----------------------------------------------------------------------------
module wra_ctrl
    import wra_pkg::*;
#(
    parameter int SUM_W = SUM_W_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_clear,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int STEP_W = $clog2(SUM_W);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic                w_last_step;

    assign w_last_step = (r_step == STEP_W'(SUM_W - 1));

    // State and division step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV_LOAD) begin
                r_step <= '0;
            end else if (r_state == ST_DIV) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_clear ? ST_DONE : ST_UPDATE;
                end
            end
            ST_UPDATE:   n_state = ST_DIV_LOAD;
            ST_DIV_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (w_last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.take_item = i_in_valid;
            end
            ST_UPDATE:   o_cmd.update   = 1'b1;
            ST_DIV_LOAD: o_cmd.div_load = 1'b1;
            ST_DIV:      o_cmd.div_step = 1'b1;
            ST_DONE:     o_cmd.out_load = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/wra_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed running average: datapath
// Holds the configuration, the sample ring, the running sum and count, a
// restoring divider that yields one quotient bit a cycle, and the result
// register.
// ----------------------------------------------------------------------------
module wra_dp
    import wra_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int SUM_W      = SUM_W_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  t_in_item   i_in_item,
    input  logic       i_cfg_we,
    input  t_cfg_beat  i_cfg_beat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    // Only the first (2^CNT_W - 1) slots can ever be reached.
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int RING_D  = (WINDOW_MAX < CNT_MAX) ? WINDOW_MAX : CNT_MAX;
    localparam int SLOT_W  = (RING_D > 1) ? $clog2(RING_D) : 1;

    logic [CNT_W-1:0]         r_win_n;
    logic                     r_time_mode;
    logic [SLOT_W-1:0]        r_slot;
    logic [CNT_W-1:0]         r_held;
    logic signed [SUM_W-1:0]  r_sum;
    logic [DATA_W-1:0]        r_stamp;
    logic signed [DATA_W-1:0] r_newest;
    logic signed [DATA_W-1:0] r_sample;
    logic signed [DATA_W-1:0] r_old;
    logic [CNT_W-1:0]         r_rem;
    logic [SUM_W-1:0]         r_quo;
    logic                     r_neg;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic signed [DATA_W-1:0] r_ring [RING_D];

    logic                     w_full;
    logic [CNT_W-1:0]         w_slot_inc;
    logic signed [DATA_W:0]   w_swap;
    logic signed [SUM_W-1:0]  w_swap_ext;
    logic signed [SUM_W-1:0]  w_sample_ext;
    logic [CNT_W:0]           w_rem_sh;
    logic [CNT_W:0]           w_rem_sub;
    logic                     w_ge;
    logic signed [DATA_W-1:0] w_avg;

    assign w_full       = (r_held >= r_win_n);
    assign w_slot_inc   = CNT_W'(r_slot) + 1'b1;
    assign w_swap       = {r_sample[DATA_W-1], r_sample} - {r_old[DATA_W-1], r_old};
    assign w_swap_ext   = {{(SUM_W-DATA_W-1){w_swap[DATA_W]}}, w_swap};
    assign w_sample_ext = {{(SUM_W-DATA_W){r_sample[DATA_W-1]}}, r_sample};

    // One restoring division step on the magnitude of the sum.
    assign w_rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_held};
    assign w_ge      = (w_rem_sh >= {1'b0, r_held});

    // Quotient back to the sign of the sum, truncated toward zero.
    assign w_avg = r_neg ? -r_quo[DATA_W-1:0] : r_quo[DATA_W-1:0];

    // Configuration, store state and the current sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_n     <= eff_window(WINDOW_SIZE_RST, WINDOW_MAX);
            r_time_mode <= 1'b0;
            r_slot      <= '0;
            r_held      <= '0;
            r_sum       <= '0;
            r_stamp     <= '0;
            r_newest    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_beat.index)
                    CFG_WINDOW_SIZE: begin
                        r_win_n  <= eff_window(i_cfg_beat.data, WINDOW_MAX);
                        r_slot   <= '0;
                        r_held   <= '0;
                        r_sum    <= '0;
                        r_newest <= '0;
                    end
                    CFG_TIME_MODE: r_time_mode <= i_cfg_beat.data[0];
                    default: ;
                endcase
            end
            if (i_cmd.take_item) begin
                // Only the low word of the timestamp ever reaches a result.
                if (r_time_mode) begin
                    r_stamp <= i_in_item.timestamp[DATA_W-1:0];
                end
                if (i_in_item.clear) begin
                    r_slot   <= '0;
                    r_held   <= '0;
                    r_sum    <= '0;
                    r_newest <= '0;
                end
            end
            if (i_cmd.update) begin
                if (w_full) begin
                    r_sum <= r_sum + w_swap_ext;
                end else begin
                    r_sum  <= r_sum + w_sample_ext;
                    r_held <= r_held + 1'b1;
                end
                r_newest <= r_sample;
                r_slot   <= (w_slot_inc >= r_win_n) ? '0 : SLOT_W'(w_slot_inc);
            end
        end
    end

    // Sample taken from the beat: the value, the wrapped time difference, or zero on a clear.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            if (i_in_item.clear) begin
                r_sample <= '0;
            end else if (r_time_mode) begin
                r_sample <= i_in_item.timestamp[DATA_W-1:0] - r_stamp;
            end else begin
                r_sample <= i_in_item.value;
            end
        end
    end

    // Sample ring. The oldest entry is read as the beat is taken and is only
    // used once the window is full, so every entry read has been written.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_old <= r_ring[r_slot];
        end
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    // Divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= r_sum[SUM_W-1] ? -r_sum : r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[CNT_W-1:0] : w_rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.delta      <= r_sample;
            r_out.average    <= (r_held == '0) ? '0 : w_avg;
            r_out.last_value <= (r_held == '0) ? '1 : r_newest;
            r_out.fill_count <= r_held;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

endmodule

/* sv/windowed_running_average_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed running average unit
// Keeps a ring of the last N samples with their running sum and returns,
// for each item, the marked sample, the truncating average, the newest
// sample and the fill count.
// A sample beat goes through the ring update, divider load, division and
// hand-over states; a clear beat goes straight to the hand-over, which waits
// while the result register holds an untaken beat. No new beat is taken until
// the last is handed over; the bit-serial divider yields one quotient bit per cycle.
// Reset (synchronous, active low) restores window size 16, value mode and an
// empty store; no clearing pass is needed, as the fill count guards the ring.
// ----------------------------------------------------------------------------
module windowed_running_average_unit
    import wra_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wra_stream_if.sink    i_in,
    wra_stream_if.source  o_out,
    wra_stream_if.sink    i_cfg
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int N_MAX   = (WINDOW_MAX < CNT_MAX) ? WINDOW_MAX : CNT_MAX;
    localparam int SUM_W   = DATA_W + $clog2(N_MAX);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    t_in_item   w_in_item;
    t_cfg_beat  w_cfg_beat;
    t_out_item  w_out_item;
    logic       w_out_valid;

    assign w_in_item  = i_in.payload;
    assign w_cfg_beat = i_cfg.payload;
    assign i_in.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = w_out_valid;
    assign o_out.payload = w_out_item;

    // Controller.
    wra_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_clear (w_in_item.clear),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    wra_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .SUM_W      (SUM_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (w_in_item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_beat  (w_cfg_beat),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (w_out_item)
    );

    // The controller issues at most one datapath command per cycle.
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    // The result register is only loaded when it is empty or being drained.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_status.out_free)
        else $error("result register loaded while holding an untaken beat");

    // A sample beat keeps the block busy for the following cycle.
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !w_in_item.clear) |=> !i_in.ready)
        else $error("input ready straight after a sample beat");

    // An empty store reports a zero average and a newest sample of minus one.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.payload.fill_count == '0)) |->
            (o_out.payload.average == '0) && (o_out.payload.last_value == '1))
        else $error("empty store gave a non-default result");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed running average unit: self-checking testbench
// Walks a short table of directed beats (extremes, clears in both modes,
// timestamp wrap, window sizes zero and beyond the ring), then runs random
// phases under new register settings. Results are checked field by field
// with a typed value or a model of the ring, its running sum and the stored
// timestamp. Both sides idle at random, the receiver once holds off for a
// long stretch, and the sender waits for all results before each write.
// ----------------------------------------------------------------------------
module tb_top;
    import wra_pkg::*;

    localparam int RING_DEPTH   = WINDOW_MAX_DEF;
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 60;
    localparam int IDLE_PCT     = 34;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: either a sample beat or a register write.
    typedef struct {
        t_row_kind        kind;
        t_in_item         item;
        t_cfg_index       index;
        logic [CNT_W-1:0] data;
        bit               typed;
        t_out_item        result;
    } t_stim_row;

    // A result typed into the table, or none, queued in step with the beats.
    typedef struct {
        bit        typed;
        t_out_item result;
    } t_typed_result;

    logic i_clk;
    logic i_rst_n;

    wra_stream_if #(.T(t_in_item))  sample_ch ();
    wra_stream_if #(.T(t_out_item)) result_ch ();
    wra_stream_if #(.T(t_cfg_beat)) cfg_ch ();

    windowed_running_average_unit #(
        .WINDOW_MAX(RING_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    // Model of the block's state and registers.
    logic signed [DATA_W-1:0] ring_m [RING_DEPTH];
    int                       slot_m;
    int                       held_m;
    longint                   sum_m;
    logic [STAMP_W-1:0]       stamp_m;
    logic [CNT_W-1:0]         win_size_m;
    bit                       time_mode_m;

    t_out_item     pending_averages [$];
    t_typed_result typed_results [$];
    t_stim_row     dir_rows [$];

    int          items_sent   = 0;
    int          results_seen = 0;
    int          cfg_writes   = 0;
    int          clears_seen  = 0;
    int          err_count    = 0;
    int unsigned cycle_count  = 0;

    bit                 tx_idle_en    = 1'b1;
    bit                 rx_idle_en    = 1'b1;
    bit                 hold_req      = 1'b0;
    bit                 cur_time_mode = 1'b0;
    logic [STAMP_W-1:0] stamp_cursor  = '0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Empties the modelled store; the last timestamp is kept.
    function automatic void clear_model();
        for (int k = 0; k < RING_DEPTH; k++) begin
            ring_m[k] = '0;
        end
        slot_m = 0;
        held_m = 0;
        sum_m  = 0;
    endfunction

    function automatic void reset_model();
        win_size_m  = WINDOW_SIZE_RST;
        time_mode_m = 1'b0;
        stamp_m     = '0;
        clear_model();
    endfunction

    // A window size write empties the store; a mode write leaves it alone.
    function automatic void apply_reg_write(input t_cfg_beat beat);
        if (beat.index == CFG_WINDOW_SIZE) begin
            win_size_m = beat.data;
            clear_model();
        end else begin
            time_mode_m = beat.data[0];
        end
    endfunction

    // Works out the result of one sample beat and advances the model.
    function automatic t_out_item predict_average(input t_in_item it);
        t_out_item                r;
        int                       n;
        int                       slot;
        logic [STAMP_W-1:0]       diff;
        logic signed [DATA_W-1:0] smp;
        longint                   avg;
        // Size zero acts as one sample; anything past the ring is saturated.
        n = int'(win_size_m);
        if (n == 0) begin
            n = 1;
        end else if (n > RING_DEPTH) begin
            n = RING_DEPTH;
        end
        if (it.clear) begin
            clear_model();
            if (time_mode_m) begin
                stamp_m = it.timestamp;
            end
            r.delta      = '0;
            r.average    = '0;
            r.last_value = -1;
            r.fill_count = '0;
            return r;
        end
        if (time_mode_m) begin
            diff    = it.timestamp - stamp_m;
            smp     = diff[DATA_W-1:0];
            stamp_m = it.timestamp;
        end else begin
            smp = it.value;
        end
        slot = slot_m;
        if (slot >= n) begin
            slot = 0;
        end
        // A full window drops the sample that the new one overwrites.
        if (held_m >= n) begin
            sum_m = sum_m - longint'(ring_m[slot]);
        end else begin
            held_m++;
        end
        ring_m[slot] = smp;
        sum_m = sum_m + longint'(smp);
        slot++;
        if (slot >= n) begin
            slot = 0;
        end
        slot_m = slot;
        avg = sum_m / longint'(held_m);
        r.delta      = smp;
        r.average    = avg[DATA_W-1:0];
        r.last_value = smp;
        r.fill_count = held_m[CNT_W-1:0];
        return r;
    endfunction

    // Directed table helpers.
    function automatic t_stim_row item_row(input logic signed [DATA_W-1:0] value,
                                           input logic [STAMP_W-1:0] stamp,
                                           input logic clr);
        t_stim_row row;
        row.kind           = ROW_ITEM;
        row.item.value     = value;
        row.item.timestamp = stamp;
        row.item.clear     = clr;
        row.index          = CFG_WINDOW_SIZE;
        row.data           = '0;
        row.typed          = 1'b0;
        row.result         = '0;
        return row;
    endfunction

    function automatic t_stim_row typed_row(input logic signed [DATA_W-1:0] value,
                                            input logic [STAMP_W-1:0] stamp,
                                            input logic clr,
                                            input logic signed [DATA_W-1:0] d,
                                            input logic signed [DATA_W-1:0] a,
                                            input logic signed [DATA_W-1:0] l,
                                            input logic [CNT_W-1:0] f);
        t_stim_row row;
        row = item_row(value, stamp, clr);
        row.typed             = 1'b1;
        row.result.delta      = d;
        row.result.average    = a;
        row.result.last_value = l;
        row.result.fill_count = f;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input t_cfg_index idx,
                                          input logic [CNT_W-1:0] data);
        t_stim_row row;
        row = item_row('0, '0, 1'b0);
        row.kind  = ROW_CFG;
        row.index = idx;
        row.data  = data;
        return row;
    endfunction

    // Directed table: starts from reset, window 16 in value mode.
    function automatic void build_rows();
        // Clear on an empty store, then the two extremes.
        dir_rows.push_back(typed_row(0, 0, 1'b1, 0, 0, -1, 0));
        dir_rows.push_back(typed_row(32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1));
        dir_rows.push_back(typed_row(32'sh8000_0000, 0, 1'b0,
                                     32'sh8000_0000, 0, 32'sh8000_0000, 2));
        dir_rows.push_back(item_row(-1, 64'h5555_5555_AAAA_AAAA, 1'b0));
        // Size zero behaves as a window of one.
        dir_rows.push_back(cfg_row(CFG_WINDOW_SIZE, 9'd0));
        dir_rows.push_back(typed_row(5, 0, 1'b0, 5, 5, 5, 1));
        dir_rows.push_back(typed_row(-7, 0, 1'b0, -7, -7, -7, 1));
        // Window of two, wrapping once.
        dir_rows.push_back(cfg_row(CFG_WINDOW_SIZE, 9'd2));
        dir_rows.push_back(item_row(-3, 0, 1'b0));
        dir_rows.push_back(item_row(4, 0, 1'b0));
        dir_rows.push_back(item_row(10, 0, 1'b0));
        // Time mode: clear takes the stamp, then forward, backward and wrapping steps.
        dir_rows.push_back(cfg_row(CFG_TIME_MODE, 9'd1));
        dir_rows.push_back(typed_row(32'h1234_5678, 64'd1000, 1'b1, 0, 0, -1, 0));
        dir_rows.push_back(typed_row(-1, 64'd1500, 1'b0, 500, 500, 500, 1));
        dir_rows.push_back(typed_row(0, 64'd1400, 1'b0, -100, 200, -100, 2));
        dir_rows.push_back(typed_row(32'sh7FFF_FFFF, 64'd1400 + 64'h1_0000_0005, 1'b0,
                                     5, -47, 5, 2));
        dir_rows.push_back(item_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        dir_rows.push_back(item_row(0, 64'd0, 1'b0));
        // Back to value mode without clearing; a clear here leaves the stamp.
        dir_rows.push_back(cfg_row(CFG_TIME_MODE, 9'd0));
        dir_rows.push_back(item_row(100, 64'd77, 1'b0));
        dir_rows.push_back(typed_row(0, 64'hDEAD, 1'b1, 0, 0, -1, 0));
        dir_rows.push_back(cfg_row(CFG_TIME_MODE, 9'd1));
        dir_rows.push_back(typed_row(0, 64'd10, 1'b0, 10, 10, 10, 1));
        // Size beyond the ring saturates.
        dir_rows.push_back(cfg_row(CFG_WINDOW_SIZE, 9'd300));
        dir_rows.push_back(cfg_row(CFG_TIME_MODE, 9'd0));
        dir_rows.push_back(typed_row(32'sh7FFF_FFFF, 0, 1'b0,
                                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1));
    endfunction

    // Random sample values lean towards the extremes and small numbers.
    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -1;
            3:       return 0;
            4, 5:    return int'($urandom_range(0, 200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    // Timestamps mostly move forward, now and then back, by 2^32 or anywhere.
    function automatic logic [STAMP_W-1:0] next_stamp();
        case ($urandom_range(0, 19))
            0:       stamp_cursor = {$urandom, $urandom};
            1:       stamp_cursor = stamp_cursor - STAMP_W'($urandom_range(1, 5000));
            2:       stamp_cursor = stamp_cursor + 64'h1_0000_0000
                                    + STAMP_W'($urandom_range(0, 1000));
            3:       stamp_cursor = stamp_cursor + {32'h0, $urandom};
            default: stamp_cursor = stamp_cursor + STAMP_W'($urandom_range(1, 40000));
        endcase
        return stamp_cursor;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.clear = ($urandom_range(0, 99) < 4);
        it.value = random_value();
        if (cur_time_mode) begin
            it.timestamp = next_stamp();
        end else begin
            it.timestamp = {$urandom, $urandom};
        end
        return it;
    endfunction

    function automatic logic [CNT_W-1:0] pick_window();
        case ($urandom_range(0, 8))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd2;
            3:       return CNT_W'($urandom_range(3, 16));
            4:       return CNT_W'($urandom_range(17, 255));
            5:       return 9'd256;
            6:       return CNT_W'($urandom_range(257, 511));
            default: return CNT_W'($urandom_range(1, 32));
        endcase
    endfunction

    // Offers one sample beat, after an optional random gap.
    task automatic send_sample(input t_in_item it, input bit typed, input t_out_item res);
        t_typed_result tr;
        tr.typed  = typed;
        tr.result = res;
        typed_results.push_back(tr);
        if (tx_idle_en) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                sample_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.payload <= it;
        do @(posedge i_clk); while (!sample_ch.ready);
        items_sent++;
    endtask

    task automatic send_random();
        send_sample(random_item(), 1'b0, '0);
    endtask

    // Stops offering beats and waits until every result has come back.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (results_seen < items_sent) @(posedge i_clk);
    endtask

    // One register write beat; valid then goes low before the task returns.
    task automatic write_reg(input t_cfg_index idx, input logic [CNT_W-1:0] data);
        t_cfg_beat beat;
        beat.index = idx;
        beat.data  = data;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= beat;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // New setting for a random phase; the mode write carries random upper bits.
    task automatic set_phase(input logic [CNT_W-1:0] ws, input bit tm);
        logic [CNT_W-2:0] junk;
        junk = (CNT_W-1)'($urandom);
        wait_drained();
        write_reg(CFG_WINDOW_SIZE, ws);
        write_reg(CFG_TIME_MODE, {junk, tm});
        cur_time_mode = tm;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial begin
        int rand_count;
        int phase_len;
        i_rst_n           <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.payload <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.payload    <= '0;
        reset_model();
        build_rows();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[k].index, dir_rows[k].data);
            end else begin
                send_sample(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].result);
            end
        end

        // Full ring in value mode, with the receiver holding off at the start.
        set_phase(9'd256, 1'b0);
        hold_req = 1'b1;
        repeat (300) send_random();
        rand_count = 300;

        // A stretch with no idling on either side, saturated size, time mode.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_phase(9'd511, 1'b1);
        repeat (40) send_random();
        rand_count += 40;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        while (rand_count < RANDOM_ITEMS) begin
            set_phase(pick_window(), 1'($urandom_range(0, 1)));
            phase_len = $urandom_range(20, 80);
            repeat (phase_len) send_random();
            rand_count += phase_len;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_averages.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived",
                     $time, pending_averages.size());
            err_count++;
        end
        $display("Run covered %0d sample beats (%0d clears) and %0d register writes,",
                 items_sent, clears_seen, cfg_writes);
        $display("window sizes 0 to 511 in value and time mode; %0d results checked.",
                 results_seen);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: random idling, and one long hold-off when asked.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                result_ch.ready <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                result_ch.ready <= !(rx_idle_en && ($urandom_range(0, 99) < IDLE_PCT));
            end
        end
    end

    // Register writes update the model; results are checked before the beat
    // taken at the same edge is predicted.
    always @(posedge i_clk) begin : average_checker
        t_out_item     want;
        t_out_item     got;
        t_typed_result tr;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                apply_reg_write(cfg_ch.payload);
            end
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                got = result_ch.payload;
                if (pending_averages.size() == 0) begin
                    $display("%0t ns: result beat with none expected, delta %0d average %0d",
                             $time, got.delta, got.average);
                    err_count++;
                end else begin
                    want = pending_averages.pop_front();
                    check_field("delta", want.delta, got.delta);
                    check_field("average", want.average, got.average);
                    check_field("last_value", want.last_value, got.last_value);
                    check_field("fill_count", {55'd0, want.fill_count},
                                {55'd0, got.fill_count});
                end
            end
            if (sample_ch.valid && sample_ch.ready) begin
                want = predict_average(sample_ch.payload);
                tr   = typed_results.pop_front();
                if (tr.typed) begin
                    want = tr.result;
                end
                pending_averages.push_back(want);
                if (sample_ch.payload.clear) begin
                    clears_seen++;
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: run stopped after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
